/* rtl/csv_tok_pkg.sv */
// shared types and constants of the csv record tokenizer
package csv_tok_pkg;

   // line structure bytes and register reset values
   localparam logic [7:0] CHAR_CR         = 8'd13;
   localparam logic [7:0] CHAR_LF         = 8'd10;
   localparam logic [7:0] DELIMITER_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET     = 8'd34;

   // configuration register indexes
   localparam logic [0:0] REG_DELIMITER  = 1'b0;
   localparam logic [0:0] REG_QUOTE_CHAR = 1'b1;

   // output queue geometry
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned FIFO_PTR_W = 3;
   localparam int unsigned FIFO_CNT_W = 4;
   // at most this many entries queued when a new transaction is taken
   localparam logic [FIFO_CNT_W-1:0] FIFO_ROOM_LIMIT = 4'd4;

   typedef enum logic [2:0] {
      KIND_DATA   = 3'd0,
      KIND_FIELD  = 3'd1,
      KIND_RECORD = 3'd2,
      KIND_DONE   = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  field_index;
      logic [15:0] line_count;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic        quoted_mode;
      logic        quote_pending;
      logic        cr_pending;
      logic        line_open;
      logic [7:0]  field_counter;
      logic [15:0] lines_seen;
   } parse_state_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
      logic                  empty;
   } fifo_status_type;

endpackage

/* rtl/csv_tok_core.sv */
// per-byte parse step: next tokenizer state and up to two results
module csv_tok_core (
   input  csv_tok_pkg::parse_state_type cur_state,
   input  logic [7:0]                   char_code,
   input  logic                         end_of_input,
   input  logic [7:0]                   delimiter,
   input  logic [7:0]                   quote_char,
   output csv_tok_pkg::parse_state_type nxt_state,
   output csv_tok_pkg::result_type      result0,
   output csv_tok_pkg::result_type      result1,
   output logic [1:0]                   result_count
);

   function automatic logic [7:0] sat_inc8(input logic [7:0] v);
      sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   csv_tok_pkg::result_type ea;
   csv_tok_pkg::result_type eb;
   logic                    ea_v;
   logic                    eb_v;
   logic                    qm_open;
   logic [15:0]             lines_inc;

   always_comb begin
      nxt_state = cur_state;
      ea        = '0;
      eb        = '0;
      ea_v      = 1'b0;
      eb_v      = 1'b0;
      qm_open   = cur_state.quoted_mode & ~cur_state.quote_pending;
      lines_inc = sat_inc16(cur_state.lines_seen);

      if (end_of_input) begin
         // flush: close the open line and finish, or report an unclosed quote
         if (qm_open) begin
            eb_v           = 1'b1;
            eb.kind        = csv_tok_pkg::KIND_ERROR;
            eb.field_index = cur_state.field_counter;
            eb.line_count  = lines_inc;
         end else begin
            if (cur_state.line_open) begin
               ea_v           = 1'b1;
               ea.kind        = csv_tok_pkg::KIND_RECORD;
               ea.field_index = cur_state.field_counter;
               ea.line_count  = lines_inc;
            end
            eb_v          = 1'b1;
            eb.kind       = csv_tok_pkg::KIND_DONE;
            eb.line_count = cur_state.line_open ? lines_inc : cur_state.lines_seen;
         end
         nxt_state = '0;
      end else if (char_code == csv_tok_pkg::CHAR_LF) begin
         // newline: data inside quotes, record end of an open line otherwise
         nxt_state.cr_pending    = 1'b0;
         nxt_state.quote_pending = 1'b0;
         nxt_state.quoted_mode   = qm_open;
         if (qm_open) begin
            nxt_state.lines_seen = lines_inc;
            nxt_state.line_open  = 1'b1;
            eb_v                 = 1'b1;
            eb.kind              = csv_tok_pkg::KIND_DATA;
            eb.data_byte         = csv_tok_pkg::CHAR_LF;
            eb.field_index       = cur_state.field_counter;
            eb.line_count        = lines_inc;
         end else if (cur_state.line_open) begin
            nxt_state.lines_seen    = lines_inc;
            nxt_state.field_counter = 8'd0;
            nxt_state.line_open     = 1'b0;
            eb_v                    = 1'b1;
            eb.kind                 = csv_tok_pkg::KIND_RECORD;
            eb.field_index          = cur_state.field_counter;
            eb.line_count           = lines_inc;
         end
      end else begin
         // a held carriage return not followed by newline is plain data
         if (cur_state.cr_pending) begin
            nxt_state.cr_pending = 1'b0;
            nxt_state.line_open  = 1'b1;
            ea_v                 = 1'b1;
            ea.kind              = csv_tok_pkg::KIND_DATA;
            ea.data_byte         = csv_tok_pkg::CHAR_CR;
            ea.field_index       = cur_state.field_counter;
            ea.line_count        = cur_state.lines_seen;
         end
         eb.field_index = cur_state.field_counter;
         eb.line_count  = cur_state.lines_seen;
         if (char_code == csv_tok_pkg::CHAR_CR) begin
            nxt_state.quote_pending = 1'b0;
            nxt_state.quoted_mode   = qm_open;
            nxt_state.cr_pending    = 1'b1;
         end else if (cur_state.quote_pending && char_code == quote_char) begin
            // doubled quote inside quotes
            nxt_state.quote_pending = 1'b0;
            eb_v                    = 1'b1;
            eb.kind                 = csv_tok_pkg::KIND_DATA;
            eb.data_byte            = char_code;
         end else begin
            nxt_state.quote_pending = 1'b0;
            nxt_state.quoted_mode   = qm_open;
            nxt_state.line_open     = 1'b1;
            if (qm_open) begin
               if (char_code == quote_char) begin
                  nxt_state.quote_pending = 1'b1;
               end else begin
                  eb_v         = 1'b1;
                  eb.kind      = csv_tok_pkg::KIND_DATA;
                  eb.data_byte = char_code;
               end
            end else if (char_code == quote_char) begin
               nxt_state.quoted_mode = 1'b1;
            end else if (char_code == delimiter) begin
               eb_v                    = 1'b1;
               eb.kind                 = csv_tok_pkg::KIND_FIELD;
               nxt_state.field_counter = sat_inc8(cur_state.field_counter);
            end else begin
               eb_v         = 1'b1;
               eb.kind      = csv_tok_pkg::KIND_DATA;
               eb.data_byte = char_code;
            end
         end
      end
   end

   // pack the emitted results in order and mark the last one
   always_comb begin
      result0      = ea_v ? ea : eb;
      result1      = eb;
      result_count = {1'b0, ea_v} + {1'b0, eb_v};
      result0.last_of_run = (result_count == 2'd1);
      result1.last_of_run = 1'b1;
   end

endmodule

/* rtl/csv_tok_fifo.sv */
// result queue: takes up to two results a cycle, gives one
module csv_tok_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   push_count,
   input  csv_tok_pkg::result_type      push0,
   input  csv_tok_pkg::result_type      push1,
   input  logic                         pop,
   output csv_tok_pkg::result_type      head,
   output csv_tok_pkg::fifo_status_type status
);

   csv_tok_pkg::result_type mem [csv_tok_pkg::FIFO_DEPTH];

   logic [csv_tok_pkg::FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [csv_tok_pkg::FIFO_PTR_W-1:0] wr_ptr_in;
   logic [csv_tok_pkg::FIFO_PTR_W-1:0] wr_ptr_nx;
   logic [csv_tok_pkg::FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [csv_tok_pkg::FIFO_PTR_W-1:0] rd_ptr_in;
   logic [csv_tok_pkg::FIFO_CNT_W-1:0] count_ff;
   logic [csv_tok_pkg::FIFO_CNT_W-1:0] count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_nx = wr_ptr_ff + {{(csv_tok_pkg::FIFO_PTR_W-1){1'b0}}, 1'b1};
      wr_ptr_in = wr_ptr_ff + {{(csv_tok_pkg::FIFO_PTR_W-2){1'b0}}, push_count};
      rd_ptr_in = rd_ptr_ff + {{(csv_tok_pkg::FIFO_PTR_W-1){1'b0}}, pop};
      count_in  = count_ff + {{(csv_tok_pkg::FIFO_CNT_W-2){1'b0}}, push_count}
                           - {{(csv_tok_pkg::FIFO_CNT_W-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage writes, no reset on payload
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem[wr_ptr_nx] <= push1;
      end
   end

   assign head         = mem[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

endmodule

/* rtl/csv_record_tokenizer.sv */
// top level of the streaming csv record tokenizer
//
// Input stream (req_): one text byte per transaction in req_tdata; req_tuser
// set means end of input (no byte), which closes an open record and ends
// the text with a finished result, or gives only an unclosed-quote result.
// Output stream (rsp_): one token per transaction; rsp_tuser carries the
// kind, rsp_tdata the byte, field index and line count, and rsp_tlast marks
// the last token caused by one input transaction.
// A taken byte passes the input register, then the parse step writes its
// tokens into the result queue, from whose head they are offered.
// Throughput: one input byte per cycle while the output side keeps up; the
// output port gives one token per cycle, so a byte that yields two tokens
// needs an output transfer for each. An eight-entry result queue decouples
// the sides: req_tready drops once more than four tokens are waiting.
// Reset: queue empty, parser state cleared, delimiter ',' and quote '"'.
// A stalled receiver only fills the queue; tokens are never lost.
// The csr_ port writes delimiter (index 0) and quote character (index 1);
// write them only while the block is idle.
module csv_record_tokenizer (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [7:0]  csr_wdata,
   // byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [0:0]  req_tuser,   // [0] end_of_input
   // token output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [15:8] field_index,
                                    // [31:16] line_count
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last_of_run
);

   logic                          req_accept;
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [7:0]                    s1_char_ff;
   logic                          s1_eoi_ff;
   logic [7:0]                    delimiter_ff;
   logic [7:0]                    quote_char_ff;
   csv_tok_pkg::parse_state_type  state_ff;
   csv_tok_pkg::parse_state_type  state_in;
   csv_tok_pkg::parse_state_type  core_state;
   csv_tok_pkg::result_type       core_res0;
   csv_tok_pkg::result_type       core_res1;
   logic [1:0]                    core_count;
   logic [1:0]                    push_count;
   csv_tok_pkg::result_type       head;
   csv_tok_pkg::fifo_status_type  fifo_status;

   // input handshake: take a byte while the queue has room for two in flight
   assign req_tready  = (fifo_status.count <= csv_tok_pkg::FIFO_ROOM_LIMIT);
   assign req_accept  = req_tvalid & req_tready;
   assign s1_valid_in = req_accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff  <= csv_tok_pkg::DELIMITER_RESET;
         quote_char_ff <= csv_tok_pkg::QUOTE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            csv_tok_pkg::REG_DELIMITER:  delimiter_ff  <= csr_wdata;
            csv_tok_pkg::REG_QUOTE_CHAR: quote_char_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_char_ff <= req_tdata;
         s1_eoi_ff  <= req_tuser[0];
      end
   end

   // parse step
   csv_tok_core u_core (
      .cur_state    (state_ff),
      .char_code    (s1_char_ff),
      .end_of_input (s1_eoi_ff),
      .delimiter    (delimiter_ff),
      .quote_char   (quote_char_ff),
      .nxt_state    (core_state),
      .result0      (core_res0),
      .result1      (core_res1),
      .result_count (core_count)
   );

   assign state_in   = s1_valid_ff ? core_state : state_ff;
   assign push_count = s1_valid_ff ? core_count : 2'd0;

   // tokenizer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result queue
   csv_tok_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (core_res0),
      .push1      (core_res1),
      .pop        (rsp_tvalid & rsp_tready),
      .head       (head),
      .status     (fifo_status)
   );

   // output channel
   assign rsp_tvalid = ~fifo_status.empty;
   assign rsp_tdata  = {head.line_count, head.field_index, head.data_byte};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last_of_run;

   // queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.count <= csv_tok_pkg::FIFO_CNT_W'(csv_tok_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   // end of input always produces at least one token
   a_eoi_emits: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_eoi_ff) |-> (push_count != 2'd0))
      else $error("end of input without a token");

   // end of input returns the parser to its reset state
   a_eoi_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_eoi_ff) |=>
         (state_ff.lines_seen == 16'd0 && !state_ff.quoted_mode && !state_ff.line_open))
      else $error("parser state not cleared after end of input");

endmodule
